[src/s4ag_pkg.sv]
// Shared types and constants of the strided 4-D address generator.
`default_nettype none
package s4ag_pkg;

	localparam int OFFSET_BITS    = 22;
	localparam int LENGTH_BITS    = 16;
	localparam int ADDR_BITS      = 32;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 32;
	localparam int SETTLE_CYCLES  = 5;
	localparam int SETTLE_BITS    = $clog2(SETTLE_CYCLES + 1);

	localparam logic CMD_STEP = 1'b0;
	localparam logic CMD_LOAD = 1'b1;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_TOTAL_LENGTH  = 3'd0,
		REG_INNER_LENGTH  = 3'd1,
		REG_INNER_STRIDE  = 3'd2,
		REG_MIDDLE_LENGTH = 3'd3,
		REG_MIDDLE_STRIDE = 3'd4,
		REG_OUTER_LENGTH  = 3'd5,
		REG_OUTER_STRIDE  = 3'd6,
		REG_TOP_STRIDE    = 3'd7
	} reg_index_t;

	typedef struct packed {
		logic [ADDR_BITS-1:0]   total_length;
		logic [LENGTH_BITS-1:0] inner_length;
		logic [LENGTH_BITS-1:0] middle_length;
		logic [LENGTH_BITS-1:0] outer_length;
		logic [ADDR_BITS-1:0]   inner_stride;
		logic [ADDR_BITS-1:0]   delta_inner;
		logic [ADDR_BITS-1:0]   delta_middle;
		logic [ADDR_BITS-1:0]   delta_outer;
	} walk_cfg_t;

	typedef struct packed {
		logic [OFFSET_BITS-1:0] byte_offset;
		logic                   stream_done;
		logic [ADDR_BITS-1:0]   current_base;
	} result_t;

endpackage
`default_nettype wire

[src/s4ag_in_if.sv]
// Input channel: command word with valid/ready handshake.
`default_nettype none
interface s4ag_in_if;
	logic                           valid;
	logic                           ready;
	logic                           cmd;
	logic [s4ag_pkg::ADDR_BITS-1:0] base_value;

	modport source (output valid, output cmd, output base_value, input ready);
	modport sink (input valid, input cmd, input base_value, output ready);
endinterface
`default_nettype wire

[src/s4ag_out_if.sv]
// Output channel: address result word with valid/ready handshake.
`default_nettype none
interface s4ag_out_if;
	logic                             valid;
	logic                             ready;
	logic [s4ag_pkg::OFFSET_BITS-1:0] byte_offset;
	logic                             stream_done;
	logic [s4ag_pkg::ADDR_BITS-1:0]   current_base;

	modport source (output valid, output byte_offset, output stream_done,
		output current_base, input ready);
	modport sink (input valid, input byte_offset, input stream_done,
		input current_base, output ready);
endinterface
`default_nettype wire

[src/s4ag_rewind.sv]
// Configuration registers and precomputed rewind deltas of the address walk.
`default_nettype none
module s4ag_rewind (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [s4ag_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [s4ag_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	output s4ag_pkg::walk_cfg_t                      cfg,
	output logic                                     busy
);
	logic [s4ag_pkg::ADDR_BITS-1:0]   total_length_q;
	logic [s4ag_pkg::LENGTH_BITS-1:0] inner_length_q;
	logic [s4ag_pkg::ADDR_BITS-1:0]   inner_stride_q;
	logic [s4ag_pkg::LENGTH_BITS-1:0] middle_length_q;
	logic [s4ag_pkg::ADDR_BITS-1:0]   middle_stride_q;
	logic [s4ag_pkg::LENGTH_BITS-1:0] outer_length_q;
	logic [s4ag_pkg::ADDR_BITS-1:0]   outer_stride_q;
	logic [s4ag_pkg::ADDR_BITS-1:0]   top_stride_q;

	logic [s4ag_pkg::ADDR_BITS-1:0]   prod_inner_q;
	logic [s4ag_pkg::ADDR_BITS-1:0]   prod_middle_q;
	logic [s4ag_pkg::ADDR_BITS-1:0]   prod_outer_q;
	logic [s4ag_pkg::ADDR_BITS-1:0]   term_inner_q;
	logic [s4ag_pkg::ADDR_BITS-1:0]   term_middle_q;
	logic [s4ag_pkg::ADDR_BITS-1:0]   term_outer_q;
	logic [s4ag_pkg::ADDR_BITS-1:0]   delta_inner_q;
	logic [s4ag_pkg::ADDR_BITS-1:0]   delta_middle_q;
	logic [s4ag_pkg::ADDR_BITS-1:0]   delta_outer_q;
	logic [s4ag_pkg::SETTLE_BITS-1:0] settle_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_length_q  <= '0;
			inner_length_q  <= s4ag_pkg::LENGTH_BITS'(1);
			inner_stride_q  <= '0;
			middle_length_q <= s4ag_pkg::LENGTH_BITS'(1);
			middle_stride_q <= '0;
			outer_length_q  <= s4ag_pkg::LENGTH_BITS'(1);
			outer_stride_q  <= '0;
			top_stride_q    <= '0;
		end else if (cfg_we) begin
			case (s4ag_pkg::reg_index_t'(cfg_index))
				s4ag_pkg::REG_TOTAL_LENGTH: begin
					total_length_q <= cfg_data;
				end
				s4ag_pkg::REG_INNER_LENGTH: begin
					inner_length_q <= cfg_data[s4ag_pkg::LENGTH_BITS-1:0];
				end
				s4ag_pkg::REG_INNER_STRIDE: begin
					inner_stride_q <= cfg_data;
				end
				s4ag_pkg::REG_MIDDLE_LENGTH: begin
					middle_length_q <= cfg_data[s4ag_pkg::LENGTH_BITS-1:0];
				end
				s4ag_pkg::REG_MIDDLE_STRIDE: begin
					middle_stride_q <= cfg_data;
				end
				s4ag_pkg::REG_OUTER_LENGTH: begin
					outer_length_q <= cfg_data[s4ag_pkg::LENGTH_BITS-1:0];
				end
				s4ag_pkg::REG_OUTER_STRIDE: begin
					outer_stride_q <= cfg_data;
				end
				s4ag_pkg::REG_TOP_STRIDE: begin
					top_stride_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// rewind chain: product, rewind term, running delta per dimension
	always_ff @(posedge clk) begin
		prod_inner_q   <= s4ag_pkg::ADDR_BITS'(inner_length_q * inner_stride_q);
		prod_middle_q  <= s4ag_pkg::ADDR_BITS'(middle_length_q * middle_stride_q);
		prod_outer_q   <= s4ag_pkg::ADDR_BITS'(outer_length_q * outer_stride_q);
		term_inner_q   <= middle_stride_q - prod_inner_q;
		term_middle_q  <= outer_stride_q - prod_middle_q;
		term_outer_q   <= top_stride_q - prod_outer_q;
		delta_inner_q  <= inner_stride_q + term_inner_q;
		delta_middle_q <= delta_inner_q + term_middle_q;
		delta_outer_q  <= delta_middle_q + term_outer_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= s4ag_pkg::SETTLE_BITS'(s4ag_pkg::SETTLE_CYCLES);
		end else if (cfg_we) begin
			settle_q <= s4ag_pkg::SETTLE_BITS'(s4ag_pkg::SETTLE_CYCLES);
		end else if (settle_q != '0) begin
			settle_q <= settle_q - s4ag_pkg::SETTLE_BITS'(1);
		end
	end

	always_comb begin
		cfg.total_length  = total_length_q;
		cfg.inner_length  = inner_length_q;
		cfg.middle_length = middle_length_q;
		cfg.outer_length  = outer_length_q;
		cfg.inner_stride  = inner_stride_q;
		cfg.delta_inner   = delta_inner_q;
		cfg.delta_middle  = delta_middle_q;
		cfg.delta_outer   = delta_outer_q;
	end

	assign busy = (settle_q != '0);
endmodule
`default_nettype wire

[src/s4ag_walk.sv]
// Walk state: base, position and dimension counters, one step per accepted step word until done.
`default_nettype none
module s4ag_walk (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire s4ag_pkg::walk_cfg_t            cfg,
	input  wire logic                           clear,
	input  wire logic                           accept,
	input  wire logic                           cmd,
	input  wire logic [s4ag_pkg::ADDR_BITS-1:0] base_value,
	output s4ag_pkg::result_t                   res
);
	logic [s4ag_pkg::ADDR_BITS-1:0]   base_q;
	logic [s4ag_pkg::ADDR_BITS-1:0]   position_q;
	logic [s4ag_pkg::ADDR_BITS-1:0]   total_count_q;
	logic [s4ag_pkg::LENGTH_BITS-1:0] inner_count_q;
	logic [s4ag_pkg::LENGTH_BITS-1:0] middle_count_q;
	logic [s4ag_pkg::LENGTH_BITS-1:0] outer_count_q;

	logic                             done;
	logic                             advance;
	logic [s4ag_pkg::LENGTH_BITS-1:0] inner_inc;
	logic [s4ag_pkg::LENGTH_BITS-1:0] middle_inc;
	logic [s4ag_pkg::LENGTH_BITS-1:0] outer_inc;
	logic                             inner_wrap;
	logic                             middle_wrap;
	logic                             outer_wrap;
	logic [s4ag_pkg::ADDR_BITS-1:0]   step;
	logic [s4ag_pkg::ADDR_BITS-1:0]   addr;

	always_comb begin
		done        = (total_count_q == cfg.total_length);
		advance     = (cmd == s4ag_pkg::CMD_STEP) && !done;
		inner_inc   = inner_count_q + s4ag_pkg::LENGTH_BITS'(1);
		middle_inc  = middle_count_q + s4ag_pkg::LENGTH_BITS'(1);
		outer_inc   = outer_count_q + s4ag_pkg::LENGTH_BITS'(1);
		inner_wrap  = (inner_inc == cfg.inner_length);
		middle_wrap = inner_wrap && (middle_inc == cfg.middle_length);
		outer_wrap  = middle_wrap && (outer_inc == cfg.outer_length);
		if (outer_wrap) begin
			step = cfg.delta_outer;
		end else if (middle_wrap) begin
			step = cfg.delta_middle;
		end else if (inner_wrap) begin
			step = cfg.delta_inner;
		end else begin
			step = cfg.inner_stride;
		end
		addr = base_q + position_q;
		res.byte_offset  = advance ? addr[s4ag_pkg::OFFSET_BITS-1:0] : '0;
		res.stream_done  = done;
		res.current_base = (cmd == s4ag_pkg::CMD_LOAD) ? base_value : base_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q         <= '0;
			position_q     <= '0;
			total_count_q  <= '0;
			inner_count_q  <= '0;
			middle_count_q <= '0;
			outer_count_q  <= '0;
		end else if (clear) begin
			position_q     <= '0;
			total_count_q  <= '0;
			inner_count_q  <= '0;
			middle_count_q <= '0;
			outer_count_q  <= '0;
		end else if (accept) begin
			if (cmd == s4ag_pkg::CMD_LOAD) begin
				base_q <= base_value;
			end else if (advance) begin
				position_q    <= position_q + step;
				total_count_q <= total_count_q + s4ag_pkg::ADDR_BITS'(1);
				inner_count_q <= inner_wrap ? '0 : inner_inc;
				if (inner_wrap) begin
					middle_count_q <= middle_wrap ? '0 : middle_inc;
				end
				if (middle_wrap) begin
					outer_count_q <= outer_wrap ? '0 : outer_inc;
				end
			end
		end
	end
endmodule
`default_nettype wire

[src/s4ag_queue.sv]
// Two-entry result queue between the walk and the output channel.
`default_nettype none
module s4ag_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire s4ag_pkg::result_t push_data,
	output logic                   full,
	output logic                   pop_valid,
	input  wire logic              pop,
	output s4ag_pkg::result_t      pop_data
);
	s4ag_pkg::result_t mem_q [2];
	logic              wptr_q;
	logic              rptr_q;
	logic [1:0]        count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= !wptr_q;
			end
			if (pop) begin
				rptr_q <= !rptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign full      = (count_q == 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign pop_data  = mem_q[rptr_q];
endmodule
`default_nettype wire

[src/strided_4d_address_generator.sv]
// Top level of the strided 4-D address generator.
// Takes one command word per cycle while input ready is high and returns one result word per
// command, in order. A step word yields the 22-bit offset of base plus position and advances
// the walk until the stream is done; a load word replaces the base. Each result is registered
// in a two-entry queue, pending from the cycle after acceptance, so input flows on while the
// output stalls, until the queue is full. After reset and after every configuration write, input
// ready stays low while the rewind deltas (length times stride products and their sums) settle.
`default_nettype none
module strided_4d_address_generator (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [s4ag_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [s4ag_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	s4ag_in_if.sink                                  in_ch,
	s4ag_out_if.source                               out_ch
);
	s4ag_pkg::walk_cfg_t cfg;
	s4ag_pkg::result_t   res;
	s4ag_pkg::result_t   out_data;
	logic                busy;
	logic                full;
	logic                accept;

	assign in_ch.ready = !busy && !full;
	assign accept      = in_ch.valid && in_ch.ready;

	s4ag_rewind u_rewind (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg),
		.busy      (busy)
	);

	s4ag_walk u_walk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.clear      (cfg_we),
		.accept     (accept),
		.cmd        (in_ch.cmd),
		.base_value (in_ch.base_value),
		.res        (res)
	);

	s4ag_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (res),
		.full      (full),
		.pop_valid (out_ch.valid),
		.pop       (out_ch.valid && out_ch.ready),
		.pop_data  (out_data)
	);

	assign out_ch.byte_offset  = out_data.byte_offset;
	assign out_ch.stream_done  = out_data.stream_done;
	assign out_ch.current_base = out_data.current_base;

	a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !in_ch.ready)
		else $error("input ready high right after a configuration write");

	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> out_ch.valid)
		else $error("accepted word produced no pending result");

	a_done_zero_offset: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.stream_done |-> out_ch.byte_offset == '0)
		else $error("done result carries a nonzero offset");
endmodule
`default_nettype wire
